@@ sv/fstm_pkg.sv @@
`timescale 1ns / 1ps

package fstm_pkg;

  // Operation codes carried on the input tuser.
  typedef enum logic [1:0] {
    OP_WRITE_TEXEL = 2'd0,
    OP_WRITE_LIGHT = 2'd1,
    OP_START_SPAN  = 2'd2,
    OP_STEP_PIXEL  = 2'd3
  } op_e;

  // Field widths of one request.
  localparam int OpW    = 2;
  localparam int IndexW = 12;
  localparam int ByteW  = 8;
  localparam int CoordW = 32;
  localparam int PixW   = 10;
  localparam int LightW = 8;

  // Integer part of a 16.16 coordinate starts here.
  localparam int FracBits = 16;

  // Input tdata layout, lowest bit first.
  localparam int IndexLo  = 0;
  localparam int ValueLo  = IndexLo + IndexW;
  localparam int StartULo = ValueLo + ByteW;
  localparam int StartVLo = StartULo + CoordW;
  localparam int StepULo  = StartVLo + CoordW;
  localparam int StepVLo  = StepULo + CoordW;
  localparam int PixLo    = StepVLo + CoordW;
  localparam int InBits   = PixLo + PixW;
  localparam int InDataW  = ((InBits + 7) / 8) * 8;

  // Output tdata holds the color only.
  localparam int OutDataW = ByteW;

  // Per-request pixel flags handed from the span control to the pipeline.
  typedef struct packed {
    logic emit;
    logic last;
  } span_pix_t;

endpackage

@@ sv/flat_span_texture_mapper.sv @@
`timescale 1ns / 1ps

// Horizontal span texture mapper over a square tile of 8-bit texels with a
// 256-entry light remap table. It takes one request every clock cycle unless
// the result side stalls it, and gives one color per step pixel, so a span
// streams at one pixel per clock while unstalled. A step pixel passes
// through the registered read of the texel memory, the registered read of the
// light table and the output register. Both memories hold whatever
// they held until written; there is no clearing pass after reset, and each
// entry must be written before a pixel reads it. Back-pressure on the result
// side stalls the pipeline stage by stage and reaches the request side only
// once every stage is full.
module flat_span_texture_mapper
  import fstm_pkg::*;
#(
  parameter int TILE_BITS = 6,
  parameter int MAX_SPAN  = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // table_index[11:0], table_value[19:12], start_u[51:20], start_v[83:52],
  // step_u[115:84], step_v[147:116], pixels_minus_one[157:148], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // operation[1:0]
  input  logic [OpW-1:0]      s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // color[7:0]
  output logic [OutDataW-1:0] m_axis_tdata,
  // last_of_span
  output logic                m_axis_tlast
);

  localparam int TexAddrW = 2 * TILE_BITS;

  op_e                 op;
  logic                in_fire;
  logic                a_ready, b_ready, c_ready;
  logic [TexAddrW-1:0] texel_addr;
  span_pix_t           pix;
  logic [ByteW-1:0]    texel;
  logic [ByteW-1:0]    light_color;
  logic                a_valid_q, a_last_q;
  logic                b_valid_q, b_last_q;
  logic                out_valid_q, out_last_q;
  logic [ByteW-1:0]    out_color_q;

  assign op = op_e'(s_axis_tuser);

  // Each stage moves on when the stage after it is empty or moving.
  assign c_ready       = !out_valid_q || m_axis_tready;
  assign b_ready       = !b_valid_q || c_ready;
  assign a_ready       = !a_valid_q || b_ready;
  assign s_axis_tready = a_ready;
  assign in_fire       = s_axis_tvalid && a_ready;

  fstm_span_ctrl #(
    .TILE_BITS(TILE_BITS),
    .MAX_SPAN (MAX_SPAN)
  ) u_span_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (in_fire),
    .op_i              (op),
    .start_u_i         (s_axis_tdata[StartULo +: CoordW]),
    .start_v_i         (s_axis_tdata[StartVLo +: CoordW]),
    .step_u_i          (s_axis_tdata[StepULo +: CoordW]),
    .step_v_i          (s_axis_tdata[StepVLo +: CoordW]),
    .pixels_minus_one_i(s_axis_tdata[PixLo +: PixW]),
    .texel_addr_o      (texel_addr),
    .pix_o             (pix)
  );

  // Texel tile: written by texel requests, read when a step pixel of a live span is taken.
  fstm_ram #(
    .WIDTH(ByteW),
    .DEPTH(1 << TexAddrW)
  ) u_tile_ram (
    .clk_i  (clk_i),
    .we_i   (in_fire && (op == OP_WRITE_TEXEL)),
    .waddr_i(TexAddrW'(s_axis_tdata[IndexLo +: IndexW])),
    .wdata_i(s_axis_tdata[ValueLo +: ByteW]),
    .re_i   (pix.emit),
    .raddr_i(texel_addr),
    .rdata_o(texel)
  );

  // Light table: read with the texel as the pixel leaves the first stage.
  fstm_ram #(
    .WIDTH(ByteW),
    .DEPTH(1 << LightW)
  ) u_light_ram (
    .clk_i  (clk_i),
    .we_i   (in_fire && (op == OP_WRITE_LIGHT)),
    .waddr_i(s_axis_tdata[IndexLo +: LightW]),
    .wdata_i(s_axis_tdata[ValueLo +: ByteW]),
    .re_i   (a_valid_q && b_ready),
    .raddr_i(texel),
    .rdata_o(light_color)
  );

  // Pipeline control: texel read in flight, light read in flight, result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= pix.emit;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        out_valid_q <= b_valid_q;
      end
    end
  end

  // Payload travelling beside the valid bits.
  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      a_last_q <= pix.last;
    end
    if (b_ready) begin
      b_last_q <= a_last_q;
    end
    if (c_ready) begin
      out_last_q  <= b_last_q;
      out_color_q <= light_color;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_color_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ sv/fstm_ram.sv @@
`timescale 1ns / 1ps

module fstm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port; the read port returns the old contents on a collision.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/fstm_span_ctrl.sv @@
`timescale 1ns / 1ps

module fstm_span_ctrl
  import fstm_pkg::*;
#(
  parameter int TILE_BITS = 6,
  parameter int MAX_SPAN  = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  op_e                    op_i,
  input  logic [CoordW-1:0]      start_u_i,
  input  logic [CoordW-1:0]      start_v_i,
  input  logic [CoordW-1:0]      step_u_i,
  input  logic [CoordW-1:0]      step_v_i,
  input  logic [PixW-1:0]        pixels_minus_one_i,
  output logic [2*TILE_BITS-1:0] texel_addr_o,
  output span_pix_t              pix_o
);

  localparam int SpanMaxInt = (MAX_SPAN - 1 > (1 << PixW) - 1) ? (1 << PixW) - 1 : MAX_SPAN - 1;
  localparam logic [PixW-1:0] SpanLimit = PixW'(SpanMaxInt);

  logic [CoordW-1:0] u_q, u_d, v_q, v_d;
  logic [CoordW-1:0] du_q, du_d, dv_q, dv_d;
  logic [PixW-1:0]   left_q, left_d;
  logic              active_q, active_d;
  logic              is_last;

  // The tile row comes from the integer bits of v, the column from those of u.
  assign texel_addr_o = {v_q[FracBits +: TILE_BITS], u_q[FracBits +: TILE_BITS]};

  assign is_last     = (left_q == '0);
  assign pix_o.emit  = fire_i && (op_i == OP_STEP_PIXEL) && active_q;
  assign pix_o.last  = is_last;

  // Span state: a start loads everything, a step in a live span advances it.
  always_comb begin
    u_d      = u_q;
    v_d      = v_q;
    du_d     = du_q;
    dv_d     = dv_q;
    left_d   = left_q;
    active_d = active_q;
    if (fire_i && (op_i == OP_START_SPAN)) begin
      u_d      = start_u_i;
      v_d      = start_v_i;
      du_d     = step_u_i;
      dv_d     = step_v_i;
      left_d   = (pixels_minus_one_i > SpanLimit) ? SpanLimit : pixels_minus_one_i;
      active_d = 1'b1;
    end else if (pix_o.emit) begin
      u_d = u_q + du_q;
      v_d = v_q + dv_q;
      if (is_last) begin
        active_d = 1'b0;
      end else begin
        left_d = left_q - PixW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q      <= '0;
      v_q      <= '0;
      du_q     <= '0;
      dv_q     <= '0;
      left_q   <= '0;
      active_q <= 1'b0;
    end else begin
      u_q      <= u_d;
      v_q      <= v_d;
      du_q     <= du_d;
      dv_q     <= dv_d;
      left_q   <= left_d;
      active_q <= active_d;
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import fstm_pkg::*;

  localparam int TileBits = 6;
  localparam int TileAddrW = 2 * TileBits;
  localparam int TileSize = 1 << TileAddrW;
  localparam int ItemsPerPhase = 165;
  localparam int NumPhases = 4;

  // The planning copy of the mapper state steers the stimulus; the tracking
  // copy follows the requests as the block accepts them.
  localparam int PLAN = 0;
  localparam int TRACK = 1;

  // One request as the stimulus sees it, before packing onto the bus.
  typedef struct packed {
    op_e               op;
    logic [IndexW-1:0] index;
    logic [ByteW-1:0]  value;
    logic [CoordW-1:0] start_u;
    logic [CoordW-1:0] start_v;
    logic [CoordW-1:0] step_u;
    logic [CoordW-1:0] step_v;
    logic [PixW-1:0]   pix_m1;
  } span_req_t;

  typedef struct packed {
    logic [LightW-1:0] color;
    logic              last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [OpW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tlast;

  span_req_t pending_reqs[$];
  pixel_t expected_pixels[$];
  span_req_t req_on_bus = '0;

  // Mapper state, one copy per side.
  logic [ByteW-1:0]  tile_mem [2][TileSize];
  logic [LightW-1:0] light_mem [2][256];
  logic [CoordW-1:0] u_acc [2];
  logic [CoordW-1:0] v_acc [2];
  logic [CoordW-1:0] u_inc [2];
  logic [CoordW-1:0] v_inc [2];
  logic [PixW-1:0]   pixels_left [2];
  logic              span_on [2];

  // Entries already loaded, so that no pixel ever reads an unloaded one.
  bit texel_loaded [TileSize];
  bit light_loaded [256];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned reqs_queued = 0;
  int unsigned reqs_taken = 0;
  int unsigned spans_taken = 0;
  int unsigned pixels_seen = 0;
  int unsigned errors = 0;

  flat_span_texture_mapper #(
    .TILE_BITS(TileBits),
    .MAX_SPAN (1024)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Applies one request to one copy of the state; returns 1 when a pixel
  // comes out of it.
  function automatic bit shade_request(int side, span_req_t r, output pixel_t px);
    logic [TileAddrW-1:0] addr;
    bit emits;
    px = '0;
    emits = 1'b0;
    case (r.op)
      OP_WRITE_TEXEL: begin
        tile_mem[side][r.index[TileAddrW-1:0]] = r.value;
      end
      OP_WRITE_LIGHT: begin
        light_mem[side][r.index[7:0]] = r.value;
      end
      OP_START_SPAN: begin
        // A new start drops whatever span was running.
        u_acc[side] = r.start_u;
        v_acc[side] = r.start_v;
        u_inc[side] = r.step_u;
        v_inc[side] = r.step_v;
        pixels_left[side] = r.pix_m1;
        span_on[side] = 1'b1;
      end
      default: begin
        if (span_on[side]) begin
          addr = {v_acc[side][FracBits +: TileBits], u_acc[side][FracBits +: TileBits]};
          px.color = light_mem[side][tile_mem[side][addr]];
          px.last = (pixels_left[side] == '0);
          if (px.last) begin
            span_on[side] = 1'b0;
          end else begin
            pixels_left[side] = pixels_left[side] - 1'b1;
          end
          u_acc[side] = u_acc[side] + u_inc[side];
          v_acc[side] = v_acc[side] + v_inc[side];
          emits = 1'b1;
        end
      end
    endcase
    return emits;
  endfunction

  // A request of the given kind with every field random.
  function automatic span_req_t random_req(op_e op);
    span_req_t r;
    r.op = op;
    r.index = IndexW'($urandom());
    r.value = ByteW'($urandom());
    r.start_u = $urandom();
    r.start_v = $urandom();
    r.step_u = $urandom();
    r.step_v = $urandom();
    r.pix_m1 = PixW'($urandom());
    return r;
  endfunction

  task automatic queue_req(span_req_t r);
    pixel_t px;
    void'(shade_request(PLAN, r, px));
    if (r.op == OP_WRITE_TEXEL) texel_loaded[r.index[TileAddrW-1:0]] = 1'b1;
    if (r.op == OP_WRITE_LIGHT) light_loaded[r.index[7:0]] = 1'b1;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  task automatic queue_write(op_e op, logic [IndexW-1:0] idx, logic [ByteW-1:0] val);
    span_req_t r;
    r = random_req(op);
    r.index = idx;
    r.value = val;
    queue_req(r);
  endtask

  task automatic queue_start(logic [CoordW-1:0] su, logic [CoordW-1:0] sv,
                             logic [CoordW-1:0] du, logic [CoordW-1:0] dv,
                             logic [PixW-1:0] n);
    span_req_t r;
    r = random_req(OP_START_SPAN);
    r.start_u = su;
    r.start_v = sv;
    r.step_u = du;
    r.step_v = dv;
    r.pix_m1 = n;
    queue_req(r);
  endtask

  // A step pixel, preceded by the loads that its texel and light entry need.
  task automatic queue_step();
    logic [TileAddrW-1:0] addr;
    logic [31:0] hi;
    if (span_on[PLAN]) begin
      addr = {v_acc[PLAN][FracBits +: TileBits], u_acc[PLAN][FracBits +: TileBits]};
      if (!texel_loaded[addr]) queue_write(OP_WRITE_TEXEL, addr, ByteW'($urandom()));
      if (!light_loaded[tile_mem[PLAN][addr]]) begin
        hi = $urandom();
        queue_write(OP_WRITE_LIGHT, {hi[3:0], tile_mem[PLAN][addr]}, ByteW'($urandom()));
      end
    end
    queue_req(random_req(OP_STEP_PIXEL));
  endtask

  // Either a large random step or a small one of either sign.
  function automatic logic [CoordW-1:0] random_step();
    if ($urandom_range(0, 1) == 0) return $urandom();
    return CoordW'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
  endfunction

  task automatic queue_random_span();
    int unsigned n;
    int unsigned steps;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 10);
    if (n > 14) begin
      // Long spans are abandoned early by the next start.
      steps = $urandom_range(1, 14);
    end else if ($urandom_range(0, 7) == 0) begin
      steps = $urandom_range(0, n);
    end else begin
      steps = n + 1 + $urandom_range(0, 1);
    end
    queue_start($urandom(), $urandom(), random_step(), random_step(), PixW'(n));
    repeat (steps) queue_step();
  endtask

  // Request side: takes from the pending queue and tracks what gets accepted.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    span_req_t nxt;
    pixel_t px;
    logic [InDataW-1:0] word;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (shade_request(TRACK, req_on_bus, px)) expected_pixels.push_back(px);
        if (req_on_bus.op == OP_START_SPAN) spans_taken++;
        reqs_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          word = '0;
          word[IndexLo +: IndexW] = nxt.index;
          word[ValueLo +: ByteW] = nxt.value;
          word[StartULo +: CoordW] = nxt.start_u;
          word[StartVLo +: CoordW] = nxt.start_v;
          word[StepULo +: CoordW] = nxt.step_u;
          word[StepVLo +: CoordW] = nxt.step_v;
          word[PixLo +: PixW] = nxt.pix_m1;
          req_on_bus <= nxt;
          s_axis_tdata <= word;
          s_axis_tuser <= nxt.op;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: random stalls, and each pixel checked against the oldest
  // expected one.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        pixels_seen++;
        if (expected_pixels.size() == 0) begin
          $display("%0t: pixel with none expected: color %02h last %0b",
                   $time, m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (m_axis_tdata !== want.color) begin
            $display("%0t: color expected %02h actual %02h", $time, want.color, m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned idle_by_phase [NumPhases];
    int unsigned stall_by_phase [NumPhases];
    int unsigned goal;
    idle_by_phase = '{0, 74, 0, 30};
    stall_by_phase = '{0, 0, 74, 30};
    for (int s = 0; s < 2; s++) begin
      u_acc[s] = '0;
      v_acc[s] = '0;
      u_inc[s] = '0;
      v_inc[s] = '0;
      pixels_left[s] = '0;
      span_on[s] = 1'b0;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: a step with no span, loads at the index extremes (light
    // index wider than the table), a span whose coordinates wrap through the
    // signed limits, a step after the span ended, a maximum-length span
    // abandoned by a new start, and a single-pixel span.
    queue_req(random_req(OP_STEP_PIXEL));
    queue_write(OP_WRITE_LIGHT, 12'hFFF, 8'hFF);
    queue_write(OP_WRITE_LIGHT, 12'h000, 8'h00);
    queue_write(OP_WRITE_TEXEL, 12'hFFF, 8'hFF);
    queue_write(OP_WRITE_TEXEL, 12'h000, 8'h00);
    queue_start(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0001, 10'd1);
    repeat (3) queue_step();
    queue_start(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 10'd1023);
    repeat (2) queue_step();
    queue_start(32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 10'd0);
    repeat (2) queue_step();

    // Random part, mostly whole spans with loads and stray requests mixed in.
    for (int p = 0; p < NumPhases; p++) begin
      send_idle_pct = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      goal = reqs_queued + ItemsPerPhase;
      while (reqs_queued < goal) begin
        if ($urandom_range(0, 9) < 7) begin
          queue_random_span();
        end else begin
          case ($urandom_range(0, 2))
            0: queue_write(OP_WRITE_TEXEL, IndexW'($urandom()), ByteW'($urandom()));
            1: queue_write(OP_WRITE_LIGHT, IndexW'($urandom()), ByteW'($urandom()));
            default: queue_step();
          endcase
        end
      end
      while (pending_reqs.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    end

    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d requests, %0d spans and %0d checked pixels", reqs_taken,
             spans_taken, pixels_seen);
    $display("over four handshake pressure phases; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("PASS flat_span_texture_mapper");
    end else begin
      $display("FAIL flat_span_texture_mapper");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAIL flat_span_texture_mapper");
    $finish;
  end

endmodule

@@ files.f @@
sv/fstm_pkg.sv
sv/fstm_ram.sv
sv/fstm_span_ctrl.sv
sv/flat_span_texture_mapper.sv
dv/tb.sv
